### rtl/cse_pkg.sv
// ----------------------------------------------------------------------------
// cse_pkg
// Shared types and constants of the clipped span fill engine.
// ----------------------------------------------------------------------------
package cse_pkg;

   typedef enum logic [2:0] {
      CMD_RECT   = 3'd0,
      CMD_HLINE  = 3'd1,
      CMD_VLINE  = 3'd2,
      CMD_CIRCLE = 3'd3,
      CMD_CLEAR  = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      REG_WIDTH  = 2'd0,
      REG_HEIGHT = 2'd1,
      REG_STRIDE = 2'd2
   } reg_type;

   localparam int RootW = 12;
   localparam int SqW   = 24;

   // One row slot issued by the sequencer.
   typedef struct packed {
      logic               valid;
      logic               fin;
      cmd_type            cmd;
      logic [23:0]        color;
      logic signed [12:0] xf;
      logic signed [12:0] yf;
      logic signed [12:0] xl;
      logic signed [12:0] yl;
      logic [6:0]         half;
      logic [11:0]        radius;
      logic [5:0]         py;
   } slot_type;

   // Row geometry travelling down the pipeline.
   typedef struct packed {
      logic               valid;
      logic               fin;
      logic               circ;
      logic               on;
      logic signed [14:0] lo;
      logic signed [14:0] hi;
      logic signed [12:0] xf;
      logic [23:0]        color;
      logic [5:0]         py;
   } meta_type;

   typedef struct packed {
      logic [5:0]  row;
      logic [6:0]  span_start;
      logic [6:0]  span_end;
      logic [23:0] fill_color;
      logic [17:0] byte_address;
   } span_type;

endpackage

### rtl/cse_seq.sv
// ----------------------------------------------------------------------------
// cse_seq
// Row sequencer: holds one command and issues one slot per visible row,
// followed by an end-of-command slot.
// ----------------------------------------------------------------------------
module cse_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              req_valid,
   output logic              req_ready,
   input  cse_pkg::cmd_type  cmd,
   input  logic [23:0]       color,
   input  logic signed [12:0] x_first,
   input  logic signed [12:0] y_first,
   input  logic signed [12:0] x_last,
   input  logic signed [12:0] y_last,
   input  logic [7:0]        thickness,
   input  logic [11:0]       radius,
   input  logic [6:0]        h_eff,
   output cse_pkg::slot_type slot
);

   logic              busy_ff, busy_in;
   logic [6:0]        row_ff, row_in;
   cse_pkg::slot_type hold_ff, hold_in;
   cse_pkg::slot_type slot_ff, slot_in;

   assign req_ready = !busy_ff;
   assign slot      = slot_ff;

   always_comb begin
      busy_in = busy_ff;
      row_in  = row_ff;
      hold_in = hold_ff;
      slot_in = slot_ff;
      if (!busy_ff && req_valid) begin
         busy_in        = 1'b1;
         row_in         = 7'd0;
         hold_in.cmd    = cmd;
         hold_in.color  = color;
         hold_in.xf     = x_first;
         hold_in.yf     = y_first;
         hold_in.xl     = x_last;
         hold_in.yl     = y_last;
         hold_in.half   = thickness[7:1];
         hold_in.radius = radius;
      end
      if (adv) begin
         slot_in       = hold_ff;
         slot_in.valid = busy_ff;
         slot_in.fin   = row_ff >= h_eff;
         slot_in.py    = row_ff[5:0];
         if (busy_ff) begin
            if (row_ff >= h_eff) begin
               busy_in = 1'b0;
            end else begin
               row_in = row_ff + 7'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         row_ff        <= 7'd0;
         slot_ff.valid <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         row_ff  <= row_in;
         slot_ff <= slot_in;
      end
      hold_ff <= hold_in;
   end

endmodule

### rtl/cse_geom.sv
// ----------------------------------------------------------------------------
// cse_geom
// Row coverage and span bounds per command, then the two squares that the
// circle needs (radius squared and row offset squared).
// ----------------------------------------------------------------------------
module cse_geom (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  cse_pkg::slot_type slot,
   output cse_pkg::meta_type meta,
   output logic [23:0]       r2,
   output logic [23:0]       dy2
);

   cse_pkg::meta_type  a_ff, a_in;
   logic [11:0]        mag_ff, mag_in;
   logic [11:0]        rad_ff;
   cse_pkg::meta_type  b_ff;
   logic [23:0]        r2_ff, dy2_ff;
   logic signed [14:0] py, xf, yf, xl, yl, half, rad, dy, ady;

   always_comb begin
      py   = $signed({9'b0, slot.py});
      xf   = {{2{slot.xf[12]}}, slot.xf};
      yf   = {{2{slot.yf[12]}}, slot.yf};
      xl   = {{2{slot.xl[12]}}, slot.xl};
      yl   = {{2{slot.yl[12]}}, slot.yl};
      half = $signed({8'b0, slot.half});
      rad  = $signed({3'b0, slot.radius});
      dy   = py - yf;
      ady  = dy[14] ? -dy : dy;
      a_in       = '0;
      a_in.valid = slot.valid;
      a_in.fin   = slot.fin;
      a_in.xf    = slot.xf;
      a_in.color = slot.color;
      a_in.py    = slot.py;
      mag_in     = 12'd0;
      case (slot.cmd)
         cse_pkg::CMD_RECT: begin
            a_in.on = (py >= yf) && (py <= yl);
            a_in.lo = xf;
            a_in.hi = xl;
         end
         cse_pkg::CMD_HLINE: begin
            a_in.on = (py >= yf - half) && (py <= yf + half);
            a_in.lo = xf;
            a_in.hi = xl;
         end
         cse_pkg::CMD_VLINE: begin
            a_in.on = (py >= yf) && (py <= yl);
            a_in.lo = xf - half;
            a_in.hi = xf + half;
         end
         cse_pkg::CMD_CIRCLE: begin
            a_in.circ = 1'b1;
            a_in.on   = (dy >= -rad) && (dy < rad);
            mag_in    = a_in.on ? ady[11:0] : 12'd0;
         end
         cse_pkg::CMD_CLEAR: begin
            // Right end is pulled to the canvas edge by the clip stage.
            a_in.on = 1'b1;
            a_in.lo = 15'sd0;
            a_in.hi = 15'sd16383;
         end
         default: a_in.on = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff.valid <= 1'b0;
         b_ff.valid <= 1'b0;
      end else if (adv) begin
         a_ff <= a_in;
         b_ff <= a_ff;
      end
      if (adv) begin
         mag_ff <= mag_in;
         rad_ff <= slot.radius;
         r2_ff  <= rad_ff * rad_ff;
         dy2_ff <= mag_ff * mag_ff;
      end
   end

   assign meta = b_ff;
   assign r2   = r2_ff;
   assign dy2  = dy2_ff;

endmodule

### rtl/cse_sqrt.sv
// ----------------------------------------------------------------------------
// cse_sqrt
// Pipelined rounded square root, one result bit per stage, carrying the
// row geometry alongside.
// ----------------------------------------------------------------------------
module cse_sqrt (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  cse_pkg::meta_type meta_in,
   input  logic [23:0]       r2,
   input  logic [23:0]       dy2,
   output cse_pkg::meta_type meta_out,
   output logic [12:0]       dx
);

   localparam int N = cse_pkg::RootW;

   typedef struct packed {
      cse_pkg::meta_type       meta;
      logic [cse_pkg::SqW-1:0] v;
      logic [N-1:0]            s;
      logic [cse_pkg::SqW:0]   sq;
   } root_type;

   root_type          st_ff [0:N];
   cse_pkg::meta_type out_ff;
   logic [12:0]       dx_ff, dx_in;
   logic [23:0]       rem;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff[0].meta.valid <= 1'b0;
      end else if (adv) begin
         st_ff[0].meta <= meta_in;
      end
      if (adv) begin
         st_ff[0].v  <= r2 - dy2;
         st_ff[0].s  <= '0;
         st_ff[0].sq <= '0;
      end
   end

   for (genvar k = 0; k < N; k++) begin : g_bit
      localparam int B = N - 1 - k;
      logic [cse_pkg::SqW:0] t_sq;
      root_type              nx;
      always_comb begin
         t_sq = st_ff[k].sq + ({13'b0, st_ff[k].s} << (B + 1))
                + ((cse_pkg::SqW+1)'(1) << (2 * B));
         nx   = st_ff[k];
         if (t_sq <= {1'b0, st_ff[k].v}) begin
            nx.s[B] = 1'b1;
            nx.sq   = t_sq;
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            st_ff[k+1].meta.valid <= 1'b0;
         end else if (adv) begin
            st_ff[k+1] <= nx;
         end
      end
   end

   always_comb begin
      rem   = st_ff[N].v - st_ff[N].sq[23:0];
      dx_in = {1'b0, st_ff[N].s};
      if (rem > {12'b0, st_ff[N].s}) begin
         dx_in = dx_in + 13'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else if (adv) begin
         out_ff <= st_ff[N].meta;
      end
      if (adv) begin
         dx_ff <= dx_in;
      end
   end

   assign meta_out = out_ff;
   assign dx       = dx_ff;

endmodule

### rtl/cse_emit.sv
// ----------------------------------------------------------------------------
// cse_emit
// Clips each row to the canvas, forms the byte address and holds one span
// back so that the final span of a command can carry its last flag.
// ----------------------------------------------------------------------------
module cse_emit (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  cse_pkg::meta_type  meta,
   input  logic [12:0]        dx,
   input  logic signed [14:0] wm1,
   input  logic [12:0]        stride,
   output logic               out_valid,
   output cse_pkg::span_type  out_span,
   output logic               out_last
);

   typedef struct packed {
      logic              keep;
      logic              fin;
      cse_pkg::span_type span;
   } clip_type;

   clip_type           c_ff, c_in, d_ff, d_in;
   cse_pkg::span_type  pend_ff, out_ff;
   logic               pend_v_ff, pend_v_in, out_v_ff, out_v_in, last_ff;
   logic signed [14:0] xf, dxs, lo, hi, loc, hic;

   always_comb begin
      xf  = {{2{meta.xf[12]}}, meta.xf};
      dxs = $signed({2'b0, dx});
      lo  = meta.circ ? xf - dxs : meta.lo;
      hi  = meta.circ ? xf + dxs - 15'sd1 : meta.hi;
      loc = lo[14] ? 15'sd0 : lo;
      hic = (hi > wm1) ? wm1 : hi;
      c_in                 = '0;
      c_in.keep            = meta.valid && !meta.fin && meta.on && (loc <= hic);
      c_in.fin             = meta.valid && meta.fin;
      c_in.span.row        = meta.py;
      c_in.span.span_start = loc[6:0];
      c_in.span.span_end   = hic[6:0];
      c_in.span.fill_color = meta.color;
   end

   // Address stage and the hold-back decision.
   always_comb begin
      d_in                   = c_ff;
      d_in.span.byte_address = 18'({11'b0, c_ff.span.span_start} * 18'd3
                                   + c_ff.span.row * stride);
      out_v_in  = 1'b0;
      pend_v_in = pend_v_ff;
      if (d_ff.fin) begin
         out_v_in  = pend_v_ff;
         pend_v_in = 1'b0;
      end else if (d_ff.keep) begin
         out_v_in  = pend_v_ff;
         pend_v_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_ff.keep <= 1'b0;
         c_ff.fin  <= 1'b0;
         d_ff.keep <= 1'b0;
         d_ff.fin  <= 1'b0;
         pend_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else if (adv) begin
         c_ff      <= c_in;
         d_ff      <= d_in;
         out_v_ff  <= out_v_in;
         pend_v_ff <= pend_v_in;
      end
      if (adv && (d_ff.fin || d_ff.keep)) begin
         out_ff  <= pend_ff;
         last_ff <= d_ff.fin;
         if (d_ff.keep) begin
            pend_ff <= d_ff.span;
         end
      end
   end

   assign out_valid = out_v_ff;
   assign out_span  = out_ff;
   assign out_last  = last_ff;

endmodule

### rtl/clipped_span_fill_engine.sv
// ----------------------------------------------------------------------------
// clipped_span_fill_engine
// Turns draw commands into clipped horizontal spans, at most one per row.
// ----------------------------------------------------------------------------
// A draw request (rectangle, thick horizontal or vertical line, filled circle
// or clear) enters on the req_ stream; its spans leave on the rsp_ stream in
// increasing row order, with tlast on the final span of each request. A
// request that covers no visible row gives no span at all.
// The sequencer walks the visible rows, one row per cycle while the pipeline
// advances, and adds one slot to close the request; it takes no new request
// during that walk, and the next request is taken as soon as that walk
// ends, while the rows of the previous one are still in flight.
// Each row passes a two-stage geometry unit, a rounded square root with one
// result bit per stage, a clip stage, an address stage and a one-span
// hold-back buffer: the first span is offered once the next row that gives a
// span, or the closing slot, reaches the buffer.
// The csr_ port writes canvas_width, canvas_height and row_stride (indexes
// 0 to 2) and is always ready; writes belong to idle periods.
// Reset empties the pipeline and restores 128 x 64 pixels and 384 bytes per
// row. When the receiver holds rsp_tready low while a span is offered, the
// whole pipeline and the row walk freeze in place and resume without loss.
// ----------------------------------------------------------------------------
module clipped_span_fill_engine #(
   parameter int MAX_WIDTH  = 128,
   parameter int MAX_HEIGHT = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // color[23:0], x_first[36:24], y_first[49:37], x_last[62:50],
   // y_last[75:63], thickness[83:76], radius[95:84]
   input  logic [95:0] req_tdata,
   // cmd[2:0]
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // row[5:0], span_start[12:6], span_end[19:13], fill_color[43:20],
   // byte_address[61:44], zero[63:62]
   output logic [63:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_data
);

   logic [7:0]         width_ff;
   logic [6:0]         height_ff;
   logic [12:0]        stride_ff;
   logic [12:0]        w_eff;
   logic [6:0]         h_eff;
   logic signed [14:0] wm1;
   logic               adv;
   cse_pkg::slot_type  slot;
   cse_pkg::meta_type  geo_meta, root_meta;
   logic [23:0]        r2, dy2;
   logic [12:0]        dx;
   cse_pkg::span_type  span;

   assign csr_ready = 1'b1;

   // Configuration registers; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 8'd128;
         height_ff <= 7'd64;
         stride_ff <= 13'd384;
      end else if (csr_valid) begin
         unique case (cse_pkg::reg_type'(csr_index))
            cse_pkg::REG_WIDTH:  width_ff  <= csr_data[7:0];
            cse_pkg::REG_HEIGHT: height_ff <= csr_data[6:0];
            cse_pkg::REG_STRIDE: stride_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Effective canvas, limited to the build-time maximum.
   assign w_eff = ({5'b0, width_ff} < 13'(MAX_WIDTH)) ? {5'b0, width_ff} : 13'(MAX_WIDTH);
   assign h_eff = (height_ff < 7'(MAX_HEIGHT)) ? height_ff : 7'(MAX_HEIGHT);
   assign wm1   = $signed({2'b0, w_eff}) - 15'sd1;

   // The whole pipeline moves together whenever the output register is free.
   assign adv = !rsp_tvalid || rsp_tready;

   cse_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .cmd       (cse_pkg::cmd_type'(req_tuser)),
      .color     (req_tdata[23:0]),
      .x_first   (req_tdata[36:24]),
      .y_first   (req_tdata[49:37]),
      .x_last    (req_tdata[62:50]),
      .y_last    (req_tdata[75:63]),
      .thickness (req_tdata[83:76]),
      .radius    (req_tdata[95:84]),
      .h_eff     (h_eff),
      .slot      (slot)
   );

   cse_geom u_geom (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .slot  (slot),
      .meta  (geo_meta),
      .r2    (r2),
      .dy2   (dy2)
   );

   cse_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .meta_in  (geo_meta),
      .r2       (r2),
      .dy2      (dy2),
      .meta_out (root_meta),
      .dx       (dx)
   );

   cse_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .meta      (root_meta),
      .dx        (dx),
      .wm1       (wm1),
      .stride    (stride_ff),
      .out_valid (rsp_tvalid),
      .out_span  (span),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {2'b00, span.byte_address, span.fill_color, span.span_end,
                       span.span_start, span.row};

`ifndef SYNTH
   // A delivered span is never empty.
   a_span_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (span.span_start <= span.span_end))
      else $error("span start beyond span end");

   // Spans stay inside the visible canvas.
   a_span_col: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ({6'b0, span.span_end} < w_eff))
      else $error("span end outside canvas");

   a_span_row: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ({1'b0, span.row} < h_eff))
      else $error("span row outside canvas");
`endif

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the clipped span fill engine.
// ----------------------------------------------------------------------------
// Draw requests are queued by a stimulus block in phases. Each phase starts
// from an idle engine; later ones set their own canvas. A clocked driver takes
// requests from that queue. When a request is accepted, a span predictor
// works out the spans the request should give and appends them to the
// expected-span queue. A clocked monitor compares every span that comes out
// with the oldest expected span, field by field. Both handshakes idle at
// random, except during one long stretch.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [2:0]         cmd;
      logic [23:0]        color;
      logic signed [12:0] xf;
      logic signed [12:0] yf;
      logic signed [12:0] xl;
      logic signed [12:0] yl;
      logic [7:0]         thick;
      logic [11:0]        radius;
   } draw_type;

   typedef struct {
      logic [5:0]  row;
      logic [6:0]  first_col;
      logic [6:0]  last_col;
      logic [23:0] color;
      logic [17:0] addr;
      logic        tail;
   } span_exp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [12:0] csr_data = '0;

   draw_type     draw_queue[$];
   span_exp_type span_queue[$];
   draw_type     in_flight;
   bit           calm = 1'b0;
   int           error_count = 0;

   // The engine's canvas registers, mirrored.
   int unsigned  canvas_w = 128;
   int unsigned  canvas_h = 64;
   int unsigned  stride = 384;

   clipped_span_fill_engine u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch on %s: got %0d, expected %0d", what, got, want);
      error_count++;
   endtask

   // Rounded square root, floor(sqrt(v) + 0.5), worked out bit by bit.
   function automatic longint round_root(input longint v);
      longint s;
      longint t;
      s = 0;
      for (int b = 13; b >= 0; b--) begin
         t = s | (longint'(1) << b);
         if (t * t <= v) s = t;
      end
      if (v - s * s > s) s++;
      return s;
   endfunction

   // Spans of one draw request, top row first.
   task automatic predict_spans(input draw_type d);
      int           w, h, half, r, lo, hi, dy, first_idx;
      bit           on;
      longint       addr;
      span_exp_type s;
      w = (canvas_w < 128) ? canvas_w : 128;
      h = (canvas_h < 64) ? canvas_h : 64;
      half = int'(d.thick) / 2;
      r = int'(d.radius);
      first_idx = span_queue.size();
      if (d.cmd > 3'(cse_pkg::CMD_CLEAR)) return;
      for (int py = 0; py < h; py++) begin
         lo = 0;
         hi = -1;
         case (d.cmd)
            3'(cse_pkg::CMD_RECT): begin
               on = py >= d.yf && py <= d.yl; lo = int'(d.xf); hi = int'(d.xl);
            end
            3'(cse_pkg::CMD_HLINE): begin
               on = py >= d.yf - half && py <= d.yf + half;
               lo = int'(d.xf); hi = int'(d.xl);
            end
            3'(cse_pkg::CMD_VLINE): begin
               on = py >= d.yf && py <= d.yl;
               lo = int'(d.xf) - half; hi = int'(d.xf) + half;
            end
            3'(cse_pkg::CMD_CIRCLE): begin
               dy = py - int'(d.yf);
               on = dy >= -r && dy < r;
               if (on) begin
                  lo = int'(d.xf) - int'(round_root(longint'(r) * r - longint'(dy) * dy));
                  hi = 2 * int'(d.xf) - lo - 1;
               end
            end
            default: begin
               on = 1'b1; lo = 0; hi = w - 1;
            end
         endcase
         if (!on) continue;
         if (lo < 0) lo = 0;
         if (hi > w - 1) hi = w - 1;
         if (lo > hi) continue;
         addr = longint'(lo) * 3 + longint'(py) * stride;
         s.row = py[5:0];
         s.first_col = lo[6:0];
         s.last_col = hi[6:0];
         s.color = d.color;
         s.addr = addr[17:0];
         s.tail = 1'b0;
         span_queue.push_back(s);
      end
      if (span_queue.size() > first_idx) span_queue[$].tail = 1'b1;
   endtask

   // Request driver: the predictor runs on each request as it is accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) predict_spans(in_flight);
         if (!req_tvalid || req_tready) begin
            if (draw_queue.size() > 0 && (calm || $urandom_range(99) >= 38)) begin
               in_flight = draw_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= in_flight.cmd;
               req_tdata <= {in_flight.radius, in_flight.thick, in_flight.yl,
                             in_flight.xl, in_flight.yf, in_flight.xf, in_flight.color};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Span monitor and back-pressure.
   always @(posedge clock) begin
      span_exp_type e;
      rsp_tready <= calm || $urandom_range(99) >= 38;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (span_queue.size() == 0) begin
            $display("unexpected span, row %0d", rsp_tdata[5:0]);
            error_count++;
         end else begin
            e = span_queue.pop_front();
            if (rsp_tdata[5:0] !== e.row) report("row", rsp_tdata[5:0], e.row);
            if (rsp_tdata[12:6] !== e.first_col)
               report("span_start", rsp_tdata[12:6], e.first_col);
            if (rsp_tdata[19:13] !== e.last_col)
               report("span_end", rsp_tdata[19:13], e.last_col);
            if (rsp_tdata[43:20] !== e.color)
               report("fill_color", rsp_tdata[43:20], e.color);
            if (rsp_tdata[61:44] !== e.addr)
               report("byte_address", rsp_tdata[61:44], e.addr);
            if (rsp_tlast !== e.tail) report("last", rsp_tlast, e.tail);
         end
      end
      if (!reset && csr_valid && csr_ready) begin
         case (csr_index)
            cse_pkg::REG_WIDTH:  canvas_w = csr_data[7:0];
            cse_pkg::REG_HEIGHT: canvas_h = csr_data[6:0];
            cse_pkg::REG_STRIDE: stride = csr_data;
            default: ;
         endcase
      end
   end

   task automatic write_reg(input cse_pkg::reg_type idx, input logic [12:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic set_canvas(input logic [12:0] w, input logic [12:0] h, input logic [12:0] s);
      write_reg(cse_pkg::REG_WIDTH, w);
      write_reg(cse_pkg::REG_HEIGHT, h);
      write_reg(cse_pkg::REG_STRIDE, s);
   endtask

   function automatic draw_type make_draw(input logic [2:0] c, input int xf, input int yf,
                                          input int xl, input int yl, input int t,
                                          input int r, input logic [23:0] col);
      draw_type d;
      d.cmd = c; d.color = col;
      d.xf = 13'(xf); d.yf = 13'(yf); d.xl = 13'(xl); d.yl = 13'(yl);
      d.thick = 8'(t); d.radius = 12'(r);
      return d;
   endfunction

   // Mostly shapes near the canvas; one in ten at random has raw field values.
   function automatic draw_type random_draw();
      draw_type d;
      int       a, b;
      if ($urandom_range(9) == 0) begin
         d.cmd = 3'($urandom_range(7));
         d.color = 24'($urandom);
         d.xf = 13'($urandom); d.yf = 13'($urandom);
         d.xl = 13'($urandom); d.yl = 13'($urandom);
         d.thick = 8'($urandom); d.radius = 12'($urandom);
         return d;
      end
      d.cmd = $urandom_range(99) < 4 ? 3'(cse_pkg::CMD_CLEAR) : 3'($urandom_range(3));
      d.color = 24'($urandom);
      a = int'($urandom_range(180)) - 30;
      b = int'($urandom_range(100)) - 20;
      d.xf = 13'(a); d.yf = 13'(b);
      d.xl = 13'(a + int'($urandom_range(90)) - 10);
      d.yl = 13'(b + int'($urandom_range(50)) - 8);
      d.thick = $urandom_range(99) < 80 ? 8'($urandom_range(20)) : 8'($urandom_range(255));
      d.radius = $urandom_range(99) < 85 ? 12'($urandom_range(40))
                                         : 12'($urandom_range(4095));
      return d;
   endfunction

   // Lets the engine drain completely, including requests that give no span.
   task automatic drain();
      do @(negedge clock);
      while (draw_queue.size() > 0 || req_tvalid || span_queue.size() > 0);
      repeat (120) @(negedge clock);
   endtask

   task automatic random_phase(input int count);
      for (int i = 0; i < count; i++) draw_queue.push_back(random_draw());
      drain();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed requests on the reset canvas of 128 x 64.
      draw_queue.push_back(make_draw(cse_pkg::CMD_RECT, 0, 0, 127, 63, 0, 0, 24'hFFFFFF));
      draw_queue.push_back(make_draw(cse_pkg::CMD_RECT, -4096, -4096, 4095, 4095, 0, 0,
                                     24'h000000));
      draw_queue.push_back(make_draw(cse_pkg::CMD_RECT, 10, 5, 9, 20, 0, 0, 24'h123456));
      draw_queue.push_back(make_draw(cse_pkg::CMD_RECT, 10, 20, 30, 5, 0, 0, 24'h654321));
      draw_queue.push_back(make_draw(cse_pkg::CMD_RECT, 127, 63, 200, 100, 0, 0, 24'hAAAAAA));
      draw_queue.push_back(make_draw(cse_pkg::CMD_HLINE, -5, 30, 140, 0, 0, 0, 24'h555555));
      draw_queue.push_back(make_draw(cse_pkg::CMD_HLINE, 3, 30, 50, 0, 255, 0, 24'hFF0000));
      draw_queue.push_back(make_draw(cse_pkg::CMD_HLINE, 3, 0, 50, 0, 7, 0, 24'h00FF00));
      draw_queue.push_back(make_draw(cse_pkg::CMD_HLINE, 60, 10, 20, 0, 4, 0, 24'h0000FF));
      draw_queue.push_back(make_draw(cse_pkg::CMD_VLINE, 0, -10, 0, 70, 9, 0, 24'hF0F0F0));
      draw_queue.push_back(make_draw(cse_pkg::CMD_VLINE, 127, 2, 0, 40, 255, 0, 24'h0F0F0F));
      draw_queue.push_back(make_draw(cse_pkg::CMD_VLINE, 4095, 0, 0, 63, 1, 0, 24'h111111));
      draw_queue.push_back(make_draw(cse_pkg::CMD_CIRCLE, 64, 32, 0, 0, 0, 0, 24'h222222));
      draw_queue.push_back(make_draw(cse_pkg::CMD_CIRCLE, 64, 32, 0, 0, 0, 1, 24'h333333));
      draw_queue.push_back(make_draw(cse_pkg::CMD_CIRCLE, 0, 0, 0, 0, 0, 20, 24'h444444));
      draw_queue.push_back(make_draw(cse_pkg::CMD_CIRCLE, -4096, 4095, 0, 0, 0, 4095,
                                     24'h777777));
      draw_queue.push_back(make_draw(cse_pkg::CMD_CIRCLE, 50, 30, 0, 0, 0, 4095, 24'h888888));
      draw_queue.push_back(make_draw(cse_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, 24'h999999));
      draw_queue.push_back(make_draw(3'd5, 0, 0, 127, 63, 0, 0, 24'hBBBBBB));
      draw_queue.push_back(make_draw(3'd6, 0, 0, 127, 63, 0, 0, 24'hCCCCCC));
      draw_queue.push_back(make_draw(3'd7, 0, 0, 127, 63, 0, 0, 24'hDDDDDD));
      drain();

      random_phase(70);

      // Long stretch without any idling on either side.
      calm = 1'b1;
      random_phase(40);
      calm = 1'b0;

      // Smallest canvas and stride.
      set_canvas(13'd1, 13'd1, 13'd3);
      draw_queue.push_back(make_draw(cse_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, 24'hABCDEF));
      random_phase(30);

      // Zero-sized canvases give no spans.
      set_canvas(13'd0, 13'd64, 13'd384);
      random_phase(10);
      set_canvas(13'd128, 13'd0, 13'd384);
      random_phase(10);

      // Oversized registers are clipped; the largest stride overflows the address.
      set_canvas(13'd255, 13'd127, 13'd8191);
      draw_queue.push_back(make_draw(cse_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, 24'h0A0B0C));
      random_phase(50);

      set_canvas(13'd37, 13'd20, 13'd111);
      random_phase(50);

      set_canvas(13'($urandom_range(1, 128)), 13'($urandom_range(1, 64)),
                 13'($urandom_range(3, 4096)));
      random_phase(40);

      if (error_count == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("testbench NOT OK");
      $finish;
   end

endmodule
